// ===== rtl/fda_pkg.sv =====
// Shared types, character codes and helpers for the float to decimal ASCII block.
// Used by float_to_decimal_ascii; depends on nothing else.
package fda_pkg;

  // Input beat: one value to convert
  typedef struct packed {
    logic [31:0] value_bits;
    logic [7:0]  precision;
    logic [7:0]  format_char;
  } fda_in_t;

  // Output beat: one character of text
  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
    logic       bad_input;
  } fda_out_t;

  // Rounded double: 53-bit significand with hidden bit, unbiased exponent
  typedef struct packed {
    logic [52:0]        m;
    logic signed [11:0] e;
  } fda_rnd_t;

  // Sequencer return targets after a shared arithmetic step
  typedef enum logic [1:0] {
    PH_NORMX = 2'd0,
    PH_Y     = 2'd1,
    PH_DIG   = 2'd2
  } fda_phase_t;

  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_E     = 7'h45;
  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [7:0] FMT_F_LO = 8'h66;
  localparam logic [7:0] FMT_F_UP = 8'h46;

  localparam logic [52:0] M_ONE = 53'h10000000000000;  // 1.0 and 8.0 significand
  localparam logic [52:0] M_TEN = 53'h14000000000000;  // 10.0 at exponent 3

  localparam logic [7:0] PREC_DEFAULT = 8'd7;
  localparam logic [7:0] PREC_MAX     = 8'd22;
  localparam logic [7:0] PREC_CLAMP   = 8'd23;

  // floor(v / 10) for v below 256 by reciprocal multiply
  function automatic logic [7:0] div10_8(input logic [7:0] v);
    logic [18:0] p;
    p = 19'(v) * 19'd205;
    return p[18:11];
  endfunction

  // Round to nearest even; carry out of the significand bumps the exponent
  function automatic fda_rnd_t round_ne(input logic [52:0] m, input logic r,
                                        input logic s, input logic signed [11:0] e);
    fda_rnd_t   o;
    logic [53:0] t;
    t = {1'b0, m} + 54'(r & (s | m[0]));
    if (t[53]) begin
      o.m = t[53:1];
      o.e = e + 12'sd1;
    end else begin
      o.m = t[52:0];
      o.e = e;
    end
    return o;
  endfunction

  // x >= 10.0 for a normalized nonzero double
  function automatic logic ge_ten(input logic [52:0] m, input logic signed [11:0] e);
    return (e > 12'sd3) || ((e == 12'sd3) && (m >= M_TEN));
  endfunction

endpackage

// ===== rtl/float_to_decimal_ascii.sv =====
// Top level of the float to decimal ASCII converter: sequencer plus shared
// double-precision times-ten / divide-by-ten / add unit. Depends on fda_pkg.
//
// Usage: drive item and raise start; the item is taken at a clock edge where
// start is high and busy is low. busy then stays high until the text is out.
// Each character leaves on result for one cycle with strobe high; last_char
// marks the final one. Infinity or NaN gives one beat with bad_input set, and
// busy never rises for it. The receiver cannot stall; results are never held.
// Each divide by ten yields one radix-16 quotient digit a cycle, then rounds;
// each times ten is a multiply state and then a rounding state, and each
// normalize takes 16/4/1-bit steps, then a state that sees the leading one.
// One item needs up to about 45 scaling steps, up to 60 divides building the
// rounding term and up to 61 digits. A new item can be taken at the edge that
// ends the last character's beat.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending character; there is no clearing pass.
module float_to_decimal_ascii
  import fda_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  fda_in_t  item,
  output logic     strobe,
  output fda_out_t result
);

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_NORM   = 21'h000002,
    S_SCAN   = 21'h000004,
    S_MUL    = 21'h000008,
    S_MROUND = 21'h000010,
    S_DIV    = 21'h000020,
    S_DROUND = 21'h000040,
    S_YLOOP  = 21'h000080,
    S_ADD    = 21'h000100,
    S_AROUND = 21'h000200,
    S_CARRY  = 21'h000400,
    S_PREFIX = 21'h000800,
    S_POINT0 = 21'h001000,
    S_ZEROS  = 21'h002000,
    S_DIGIT  = 21'h004000,
    S_POINT  = 21'h008000,
    S_EXPE   = 21'h010000,
    S_EXPS   = 21'h020000,
    S_EXPD1  = 21'h040000,
    S_EXPD2  = 21'h080000,
    S_DONE   = 21'h100000
  } state_t;

  state_t state;

  // working value x and rounding term y
  logic [52:0]        xm, ym;
  logic signed [11:0] xe, ye;
  logic               xz;
  logic signed [7:0]  ie, ndig, cnt;
  logic               fstyle;
  fda_phase_t         ph;

  // divider
  logic [63:0]        dd, q;
  logic [3:0]         rem, dcnt;
  logic signed [11:0] div_e;
  logic               div_y;

  // multiply / add results
  logic [56:0]        p, sum;
  logic signed [11:0] ae;

  // one-deep hold so the final character can be flagged
  logic [6:0] pend;
  logic       pend_v;

  // input decode
  logic       in_acc, in_bad, in_neg, in_zero, in_sub;
  logic [7:0] ndig0;
  assign in_acc  = start && !busy;
  assign in_bad  = &item.value_bits[30:23];
  assign in_zero = (item.value_bits[30:0] == 31'd0);
  assign in_neg  = item.value_bits[31] && !in_zero;
  assign in_sub  = (item.value_bits[30:23] == 8'd0) && !in_zero;
  assign ndig0   = (item.precision == 8'd0) ? PREC_DEFAULT :
                   (item.precision > PREC_MAX) ? PREC_CLAMP : item.precision + 8'd1;

  assign busy = (state != S_IDLE);

  // integer part and fraction of x for the digit step
  logic        kok;
  logic [5:0]  ksh;
  logic [52:0] kshift, kfrac;
  logic [6:0]  kint;
  always_comb begin
    kok    = !xz && (xe >= 12'sd0) && (xe <= 12'sd6);
    ksh    = 6'd52 - xe[5:0];
    kshift = xm >> ksh;
    kint   = (kok && (kshift < 53'd100)) ? kshift[6:0] : 7'd0;
    kfrac  = xm & ((53'd1 << ksh) - 53'd1);
  end

  // divide step: one radix-16 quotient digit
  logic [7:0] dval, dq;
  logic [3:0] drem;
  always_comb begin
    dval = {rem, dd[63:60]};
    dq   = div10_8(dval);
    drem = 4'(dval - dq * 8'd10);
  end

  // rounding of the quotient, the product and the sum
  fda_rnd_t dres, mres, ares;
  always_comb begin
    if (q[57]) begin
      dres = round_ne(q[57:5], q[4], (|q[3:0]) | (rem != 4'd0), div_e - 12'sd3);
    end else begin
      dres = round_ne(q[56:4], q[3], (|q[2:0]) | (rem != 4'd0), div_e - 12'sd4);
    end
    if (p[56]) begin
      mres = round_ne(p[56:4], p[3], |p[2:0], xe + 12'sd4);
    end else begin
      mres = round_ne(p[55:3], p[2], |p[1:0], xe + 12'sd3);
    end
    if (sum[56]) begin
      ares = round_ne(sum[56:4], sum[3], |sum[2:0], ae + 12'sd1);
    end else begin
      ares = round_ne(sum[55:3], sum[2], |sum[1:0], ae);
    end
  end

  // alignment for x + y/2
  logic signed [11:0] ybe, adiff;
  logic [52:0]        abig, asml;
  logic signed [11:0] abe;
  logic [11:0]        amag;
  logic [5:0]         amt;
  logic [111:0]       awide;
  logic [55:0]        abs_;
  logic [56:0]        asum;
  always_comb begin
    ybe   = ye - 12'sd1;
    adiff = xe - ybe;
    if (adiff >= 12'sd0) begin
      abig = xm;
      abe  = xe;
      asml = ym;
      amag = adiff;
    end else begin
      abig = ym;
      abe  = ybe;
      asml = xm;
      amag = -adiff;
    end
    amt   = (amag > 12'd63) ? 6'd63 : amag[5:0];
    awide = {asml, 3'b000, 56'd0} >> amt;
    abs_  = awide[111:56];
    asum  = {1'b0, abig, 3'b000} + {1'b0, abs_[55:1], abs_[0] | (|awide[55:0])};
  end

  // exponent digits
  logic [7:0] eabs, etens, eones;
  always_comb begin
    eabs  = (ie < 8'sd0) ? 8'(-ie) : 8'(ie);
    etens = div10_8(eabs);
    eones = eabs - 8'(etens * 8'd10);
  end

  // digit step decisions
  logic       dig_pt, nz_after, nrm_after;
  always_comb begin
    dig_pt    = (cnt == (fstyle ? ie : 8'sd0));
    nz_after  = xz || ((kint != 7'd0) && (kfrac == 53'd0));
    nrm_after = (kint != 7'd0) ? kfrac[52] : xm[52];
  end

  // character produced this cycle
  logic       push;
  logic [6:0] push_c;
  always_comb begin
    push   = 1'b0;
    push_c = CH_0;
    case (state)
      S_IDLE: begin
        push   = in_acc && !in_bad && in_neg;
        push_c = CH_MINUS;
      end
      S_PREFIX: begin
        push   = fstyle && (ie < 8'sd0);
        push_c = CH_0;
      end
      S_POINT0: begin
        push   = 1'b1;
        push_c = CH_DOT;
      end
      S_ZEROS: begin
        push   = (cnt > ie);
        push_c = CH_0;
      end
      S_DIGIT: begin
        push   = (cnt < ndig);
        push_c = kint + CH_0;
      end
      S_POINT: begin
        push   = 1'b1;
        push_c = CH_DOT;
      end
      S_EXPE: begin
        push   = 1'b1;
        push_c = CH_E;
      end
      S_EXPS: begin
        push   = 1'b1;
        push_c = CH_MINUS;
      end
      S_EXPD1: begin
        push   = 1'b1;
        push_c = (etens != 8'd0) ? (etens[6:0] + CH_0) : (eones[6:0] + CH_0);
      end
      S_EXPD2: begin
        push   = 1'b1;
        push_c = eones[6:0] + CH_0;
      end
      default: begin
        push   = 1'b0;
        push_c = CH_0;
      end
    endcase
  end

  // output beat and hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (state == S_IDLE && in_acc && in_bad) begin
        strobe           <= 1'b1;
        result.char_code <= CH_NUL;
        result.last_char <= 1'b1;
        result.bad_input <= 1'b1;
      end else if (state == S_DONE) begin
        strobe           <= 1'b1;
        result.char_code <= pend_v ? pend : CH_0;
        result.last_char <= 1'b1;
        result.bad_input <= 1'b0;
        pend_v           <= 1'b0;
      end else if (push) begin
        if (pend_v) begin
          strobe           <= 1'b1;
          result.char_code <= pend;
          result.last_char <= 1'b0;
          result.bad_input <= 1'b0;
        end
        pend   <= push_c;
        pend_v <= 1'b1;
      end
    end
  end

  // sequencer and shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= PH_NORMX;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && !in_bad) begin
            fstyle <= (item.format_char == FMT_F_LO) || (item.format_char == FMT_F_UP);
            ndig   <= $signed(ndig0);
            ie     <= 8'sd0;
            ph     <= PH_NORMX;
            xz     <= in_zero;
            if (in_sub) begin
              xm    <= {item.value_bits[22:0], 30'd0};
              xe    <= -12'sd127;
              state <= S_NORM;
            end else begin
              xm    <= {1'b1, item.value_bits[22:0], 29'd0};
              xe    <= $signed({4'd0, item.value_bits[30:23]}) - 12'sd127;
              state <= S_SCAN;
            end
          end
        end
        S_NORM: begin
          if (xm[52]) begin
            state <= (ph == PH_DIG) ? S_MUL : S_SCAN;
          end else if (xm[52:37] == 16'd0) begin
            xm <= xm << 16;
            xe <= xe - 12'sd16;
          end else if (xm[52:49] == 4'd0) begin
            xm <= xm << 4;
            xe <= xe - 12'sd4;
          end else begin
            xm <= xm << 1;
            xe <= xe - 12'sd1;
          end
        end
        S_SCAN: begin
          if (!xz && xe < 12'sd0) begin
            ie    <= ie - 8'sd1;
            state <= S_MUL;
          end else if (!xz && ge_ten(xm, xe)) begin
            ie    <= ie + 8'sd1;
            dd    <= {3'b000, xm, 8'd0};
            div_e <= xe;
            div_y <= 1'b0;
            rem   <= 4'd0;
            dcnt  <= 4'd0;
            state <= S_DIV;
          end else begin
            if (fstyle) begin
              ndig <= ndig + ie;
            end
            ym    <= M_ONE;
            ye    <= 12'sd0;
            cnt   <= 8'sd1;
            ph    <= PH_Y;
            state <= S_YLOOP;
          end
        end
        S_MUL: begin
          p     <= {1'b0, xm, 3'b000} + {3'b000, xm, 1'b0};
          state <= S_MROUND;
        end
        S_MROUND: begin
          xm    <= mres.m;
          xe    <= mres.e;
          state <= (ph == PH_DIG) ? S_DIGIT : S_SCAN;
        end
        S_DIV: begin
          q    <= {q[59:0], dq[3:0]};
          rem  <= drem;
          dd   <= dd << 4;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            state <= S_DROUND;
          end
        end
        S_DROUND: begin
          if (div_y) begin
            ym    <= dres.m;
            ye    <= dres.e;
            state <= S_YLOOP;
          end else begin
            xm    <= dres.m;
            xe    <= dres.e;
            state <= S_SCAN;
          end
        end
        S_YLOOP: begin
          if (cnt < ndig) begin
            cnt   <= cnt + 8'sd1;
            dd    <= {3'b000, ym, 8'd0};
            div_e <= ye;
            div_y <= 1'b1;
            rem   <= 4'd0;
            dcnt  <= 4'd0;
            state <= S_DIV;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (xz) begin
            xm    <= ym;
            xe    <= ybe;
            xz    <= 1'b0;
            state <= S_CARRY;
          end else begin
            sum   <= asum;
            ae    <= abe;
            state <= S_AROUND;
          end
        end
        S_AROUND: begin
          xm    <= ares.m;
          xe    <= ares.e;
          state <= S_CARRY;
        end
        S_CARRY: begin
          if (ge_ten(xm, xe)) begin
            xm <= M_ONE;
            xe <= 12'sd0;
            ie <= ie + 8'sd1;
          end
          state <= S_PREFIX;
        end
        S_PREFIX: begin
          if (fstyle && ie < 8'sd0) begin
            state <= S_POINT0;
          end else begin
            cnt   <= 8'sd0;
            state <= S_DIGIT;
          end
        end
        S_POINT0: begin
          if (ndig < 8'sd0) begin
            ie <= ie - ndig;
          end
          cnt   <= -8'sd1;
          state <= S_ZEROS;
        end
        S_ZEROS: begin
          if (cnt > ie) begin
            cnt <= cnt - 8'sd1;
          end else begin
            cnt   <= 8'sd0;
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          ph <= PH_DIG;
          if (cnt < ndig) begin
            cnt <= cnt + 8'sd1;
            if (kint != 7'd0) begin
              if (kfrac == 53'd0) begin
                xz <= 1'b1;
              end else begin
                xm <= kfrac;
              end
            end
            if (dig_pt) begin
              state <= S_POINT;
            end else if (nz_after) begin
              state <= S_DIGIT;
            end else if (!nrm_after) begin
              state <= S_NORM;
            end else begin
              state <= S_MUL;
            end
          end else if (!fstyle && ie != 8'sd0) begin
            state <= S_EXPE;
          end else begin
            state <= S_DONE;
          end
        end
        S_POINT: begin
          if (xz) begin
            state <= S_DIGIT;
          end else if (!xm[52]) begin
            state <= S_NORM;
          end else begin
            state <= S_MUL;
          end
        end
        S_EXPE: begin
          state <= (ie < 8'sd0) ? S_EXPS : S_EXPD1;
        end
        S_EXPS: begin
          state <= S_EXPD1;
        end
        S_EXPD1: begin
          state <= (etens != 8'd0) ? S_EXPD2 : S_DONE;
        end
        S_EXPD2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an infinity or NaN item answers with a flagged beat next cycle
  a_bad_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (&item.value_bits[30:23])) |=> (strobe && result.bad_input))
    else $error("bad input beat missing");

  // a flagged beat is a lone, empty, final beat
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.bad_input) |-> (result.last_char && result.char_code == CH_NUL))
    else $error("bad input beat malformed");

  // the multiplier only sees normalized nonzero operands
  a_mul_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (xm[52] && !xz))
    else $error("unnormalized multiply operand");

  // the final beat always closes the item and frees the block
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (strobe && result.last_char && !busy))
    else $error("final beat missing");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for float_to_decimal_ascii: a directed table and then random values.
// Each text is predicted in IEEE double arithmetic and checked one character
// at a time. Depends on fda_pkg and the RTL top level.
module tb;
  import fda_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  fda_in_t  item;
  logic     strobe;
  fda_out_t result;

  float_to_decimal_ascii DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .strobe(strobe), .result(result)
  );

  localparam int CYCLE_LIMIT = 5000000;
  localparam int N_RANDOM    = 350;

  fda_out_t char_q[$];
  int       errors = 0;
  int       cycles = 0;

  // Directed rows; text is empty where only the predictor decides
  typedef struct {
    logic [31:0] bits;
    logic [7:0]  prec;
    logic [7:0]  fmt;
    bit          bad;
    string       text;
  } row_t;

  row_t rows[] = '{
    '{32'h0000_0000, 8'd0,   "e", 1'b0, "0.000000"},
    '{32'h8000_0000, 8'd0,   "e", 1'b0, "0.000000"},
    '{32'h3F80_0000, 8'd0,   "e", 1'b0, "1.000000"},
    '{32'hBF80_0000, 8'd0,   "E", 1'b0, "-1.000000"},
    '{32'h3F80_0000, 8'd0,   "f", 1'b0, "1.000000"},
    '{32'h7F80_0000, 8'd0,   "e", 1'b1, ""},
    '{32'hFF80_0000, 8'd5,   "f", 1'b1, ""},
    '{32'h7FC0_0000, 8'd255, "F", 1'b1, ""},
    '{32'hFFFF_FFFF, 8'd3,   "e", 1'b1, ""},
    '{32'h7F7F_FFFF, 8'd0,   "e", 1'b0, ""},
    '{32'h7F7F_FFFF, 8'd22,  "F", 1'b0, ""},
    '{32'hFF7F_FFFF, 8'd255, "e", 1'b0, ""},
    '{32'h0000_0001, 8'd0,   "e", 1'b0, ""},
    '{32'h0000_0001, 8'd23,  "f", 1'b0, ""},
    '{32'h007F_FFFF, 8'd1,   "E", 1'b0, ""},
    '{32'h411F_FFFF, 8'd0,   "e", 1'b0, ""},
    '{32'h411F_FFFF, 8'd1,   "f", 1'b0, ""},
    '{32'h0DA2_4260, 8'd2,   "f", 1'b0, ""},
    '{32'h3DCC_CCCD, 8'd4,   "F", 1'b0, ""},
    '{32'h7149_F2CA, 8'd0,   "F", 1'b0, ""},
    '{32'h42F6_E979, 8'd255, 8'hFF, 1'b0, ""},
    '{32'hC2F6_E979, 8'd22,  8'h00, 1'b0, ""},
    '{32'h3F00_0000, 8'd1,   "e", 1'b0, ""}
  };

  // Single-precision pattern to double, exact
  function automatic real single_to_real(input logic [31:0] b);
    real r;
    if (b[30:23] == 8'd0) begin
      r = b[22:0];
      for (int i = 0; i < 149; i++) r = r * 0.5;
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(b[30:23]) - 11'd127 + 11'd1023, b[22:0], 29'd0});
  endfunction

  function automatic string add_char(input string s, input int c);
    if (s.len() >= 63) return s;
    return $sformatf("%s%c", s, c[6:0]);
  endfunction

  // Text produced for one finite value
  function automatic string format_text(input logic [31:0] b, input logic [7:0] prec,
                                        input logic [7:0] fmt);
    real   x, y;
    int    ie, nd, k, e;
    bit    fixed;
    string s;
    s = "";
    ie = 0;
    x = single_to_real(b);
    nd = (prec == 0) ? 7 : (prec > PREC_MAX ? 23 : int'(prec) + 1);
    fixed = (fmt == FMT_F_LO) || (fmt == FMT_F_UP);
    if (x < 0.0) begin
      s = add_char(s, CH_MINUS);
      x = -x;
    end
    if (x > 0.0)
      while (x < 1.0) begin x = x * 10.0; ie--; end
    while (x >= 10.0) begin x = x / 10.0; ie++; end
    if (fixed) nd += ie;
    // half a unit of the last digit, then carry repair
    y = 1.0;
    for (int i = 1; i < nd; i++) y = y / 10.0;
    x = x + y / 2.0;
    if (x >= 10.0) begin x = 1.0; ie++; end
    if (fixed && ie < 0) begin
      s = add_char(s, CH_0);
      s = add_char(s, CH_DOT);
      if (nd < 0) ie = ie - nd;
      for (int i = -1; i > ie; i--) s = add_char(s, CH_0);
    end
    for (int i = 0; i < nd; i++) begin
      k = (x >= 0.0 && x < 100.0) ? $rtoi(x) : 0;
      s = add_char(s, k + CH_0);
      if (i == (fixed ? ie : 0)) s = add_char(s, CH_DOT);
      x = (x - k) * 10.0;
    end
    if (!fixed && ie != 0) begin
      e = ie;
      s = add_char(s, CH_E);
      if (e < 0) begin
        e = -e;
        s = add_char(s, CH_MINUS);
      end
      for (k = 100; k > e; k /= 10) ;
      for (; k > 0; k /= 10) begin
        s = add_char(s, e / k + CH_0);
        e = e % k;
      end
    end
    if (s.len() == 0) s = add_char(s, CH_0);
    return s;
  endfunction

  // Queue the characters one accepted beat must produce
  function automatic void queue_chars(input fda_in_t v, input string typed, input bit bad);
    string    s;
    fda_out_t o;
    byte      ch;
    if (v.value_bits[30:23] == 8'hFF) begin
      if (typed != "" || !bad) begin
        $display("%0t table row mismatch for %h: expected text, got bad input", $time,
                 v.value_bits);
        errors++;
      end
      o.char_code = CH_NUL;
      o.last_char = 1'b1;
      o.bad_input = 1'b1;
      char_q.push_back(o);
      return;
    end
    s = format_text(v.value_bits, v.precision, v.format_char);
    if (bad || (typed != "" && typed != s)) begin
      $display("%0t table row mismatch for %h: expected \"%s\" actual \"%s\"", $time,
               v.value_bits, typed, s);
      errors++;
    end
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      o.char_code = ch[6:0];
      o.last_char = (i == s.len() - 1);
      o.bad_input = 1'b0;
      char_q.push_back(o);
    end
  endfunction

  // Send one beat after a random gap; returns once it is taken
  task automatic send_beat(input fda_in_t v, input string typed, input bit bad);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= v;
    do @(posedge clk); while (busy);
    queue_chars(v, typed, bad);
  endtask

  function automatic fda_in_t random_beat();
    fda_in_t v;
    int      r;
    v.value_bits = $urandom();
    r = $urandom_range(0, 9);
    // mostly finite values near the usual range, some raw patterns
    if (r < 6) v.value_bits[30:23] = 8'($urandom_range(90, 165));
    else if (r == 6) v.value_bits[30:23] = 8'hFF;
    else if (r == 7) v.value_bits[30:23] = 8'h00;
    r = $urandom_range(0, 9);
    v.precision = (r < 7) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: v.format_char = FMT_F_LO;
      1: v.format_char = FMT_F_UP;
      2: v.format_char = "e";
      default: v.format_char = 8'($urandom());
    endcase
    return v;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Character check and run limit
  always @(posedge clk) begin
    fda_out_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && strobe) begin
      if (char_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, result);
        errors++;
      end else begin
        want = char_q.pop_front();
        if (result.char_code !== want.char_code) begin
          $display("%0t char_code: expected %h actual %h", $time, want.char_code,
                   result.char_code);
          errors++;
        end
        if (result.last_char !== want.last_char) begin
          $display("%0t last_char: expected %b actual %b", $time, want.last_char,
                   result.last_char);
          errors++;
        end
        if (result.bad_input !== want.bad_input) begin
          $display("%0t bad_input: expected %b actual %b", $time, want.bad_input,
                   result.bad_input);
          errors++;
        end
      end
    end
  end

  initial begin
    fda_in_t v;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (rows[i]) begin
      v.value_bits  = rows[i].bits;
      v.precision   = rows[i].prec;
      v.format_char = rows[i].fmt;
      send_beat(v, rows[i].text, rows[i].bad);
    end

    // Random values; once midway, hold off until all text is out
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (char_q.size() != 0) @(posedge clk);
      end
      v = random_beat();
      send_beat(v, "", &v.value_bits[30:23]);
    end
    start <= 1'b0;

    while (char_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
